// File: src/positional_insert_queue_macros.svh
// Assertion helpers shared by the queue RTL.
`ifndef POSITIONAL_INSERT_QUEUE_MACROS_SVH
`define POSITIONAL_INSERT_QUEUE_MACROS_SVH

// Check cons in the same cycle as ante.
`define PIQ_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check cons in the cycle after ante.
`define PIQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/piq_pkg.sv
package piq_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int POS_W        = 5;
  localparam int COORD_W      = 16;
  localparam int PAIR_W       = 2 * COORD_W;
  localparam int OCC_W        = 5;
  localparam int OPER_W       = 2;
  localparam int IN_DATA_W    = 40;
  localparam int OUT_DATA_W   = 40;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2,
    OP_SEARCH = 2'd3
  } oper_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_RANGE = 2'd2,
    STAT_FULL  = 2'd3
  } stat_e;

  typedef enum logic [2:0] {
    C_HOLD,
    C_INSERT,
    C_REMOVE,
    C_SLOAD,
    C_SSHIFT
  } cell_op_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_HOLD
  } state_e;

  // Broadcast command to every cell of the row.
  typedef struct packed {
    cell_op_e            op;
    logic [PAIR_W-1:0]   key;   // y in upper half, x in lower half
  } cell_cmd_t;

  // Result word, packed with status in the lowest bits.
  typedef struct packed {
    logic [OCC_W-1:0]    occupancy;
    logic                found;
    logic [COORD_W-1:0]  removed_y;
    logic [COORD_W-1:0]  removed_x;
    stat_e               status;
  } result_t;

endpackage

// File: src/positional_insert_queue.sv
// Flow: append, insert and remove register their result, which then moves to the
//   output register once that is free; a search first walks the match tokens
//   down the row of cells, one step per entry held. No new request is taken
//   until the result has reached the output register.
// Reset: synchronous, active low; clears the entry count, FSM and output valid.
//   Entry storage is not cleared and needs no clearing pass.
`include "positional_insert_queue_macros.svh"

module positional_insert_queue #(
  parameter int CAPACITY = piq_pkg::CAPACITY_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // Request channel
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [4:0] position, [20:5] item_x, [36:21] item_y, [39:37] zero
  input  logic [piq_pkg::IN_DATA_W-1:0]      in_tdata,
  // [1:0] operation
  input  logic [piq_pkg::OPER_W-1:0]         in_tuser,
  // Result channel
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [1:0] status, [17:2] removed_x, [33:18] removed_y, [34] found,
  // [39:35] occupancy
  output logic [piq_pkg::OUT_DATA_W-1:0]     out_tdata
);
  import piq_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = (CW > POS_W) ? CW : POS_W;   // width for the range check

  // Request fields
  oper_e              in_op;
  logic [POS_W-1:0]   in_pos;
  logic [PAIR_W-1:0]  in_pair;
  logic               in_fire;

  assign in_op   = oper_e'(in_tuser);
  assign in_pos  = in_tdata[POS_W-1:0];
  assign in_pair = {in_tdata[POS_W+PAIR_W-1:POS_W+COORD_W],
                    in_tdata[POS_W+COORD_W-1:POS_W]};
  assign in_fire = in_tvalid && in_tready;

  // Control and result registers
  state_e             st_r, st_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic [CW-1:0]      scan_r, scan_nxt;
  result_t            res_r, res_nxt;
  result_t            out_r, out_nxt;
  logic               out_valid_r, out_valid_nxt;

  // Row interface
  cell_cmd_t          cmd;
  logic [CW-1:0]      cell_pos;
  logic [PAIR_W-1:0]  head_data;
  logic               head_tok;

  piq_chain #(
    .CAPACITY (CAPACITY)
  ) u_chain (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .pos       (cell_pos),
    .count     (count_r),
    .head_data (head_data),
    .head_tok  (head_tok)
  );

  // Range check on the full position field, full check on the count.
  logic pos_bad;
  logic is_full;

  assign pos_bad = (in_op == OP_INSERT) && (PW'(in_pos) > PW'(count_r));
  assign is_full = (count_r == CW'(CAPACITY));

  always_comb begin
    st_nxt        = st_r;
    count_nxt     = count_r;
    scan_nxt      = scan_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    cmd.op        = C_HOLD;
    cmd.key       = in_pair;
    cell_pos      = count_r;

    // Drop the presented result once taken.
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (st_r)
      S_IDLE: begin
        if (in_fire) begin
          res_nxt = '0;
          st_nxt  = S_HOLD;
          unique case (in_op) inside
            OP_APPEND, OP_INSERT: begin
              if (pos_bad) begin
                res_nxt.status = STAT_RANGE;
              end else if (is_full) begin
                res_nxt.status = STAT_FULL;
              end else begin
                // Append lands at the tail; insert before the given slot.
                if (in_op == OP_INSERT) begin
                  cell_pos = CW'(in_pos);
                end
                cmd.op    = C_INSERT;
                count_nxt = count_r + CW'(1);
              end
            end
            OP_REMOVE: begin
              if (count_r == '0) begin
                res_nxt.status = STAT_EMPTY;
              end else begin
                res_nxt.removed_x = head_data[COORD_W-1:0];
                res_nxt.removed_y = head_data[PAIR_W-1:COORD_W];
                cmd.op            = C_REMOVE;
                count_nxt         = count_r - CW'(1);
              end
            end
            OP_SEARCH: begin
              // Load per-cell match tokens, then walk them to the head.
              cmd.op   = C_SLOAD;
              scan_nxt = count_r;
              if (count_r != '0) begin
                st_nxt = S_SCAN;
              end
            end
            default: ;
          endcase
          res_nxt.occupancy = OCC_W'(count_nxt);
        end
      end
      S_SCAN: begin
        cmd.op        = C_SSHIFT;
        res_nxt.found = res_r.found | head_tok;
        scan_nxt      = scan_r - CW'(1);
        if (scan_r == CW'(1)) begin
          st_nxt = S_HOLD;
        end
      end
      S_HOLD: begin
        // Hand the result over once the output register is free.
        if (!out_valid_r || out_tready) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          st_nxt        = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      count_r     <= '0;
      scan_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      count_r     <= count_nxt;
      scan_r      <= scan_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload holds need no reset.
  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    out_r <= out_nxt;
  end

  assign in_tready  = (st_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_r;

  // Checks
  `PIQ_ASSERT_SAME(a_count_bound, 1'b1, count_r <= CW'(CAPACITY),
                   "count above capacity")
  `PIQ_ASSERT_NEXT(a_busy_after_req, in_fire, st_r != S_IDLE,
                   "idle right after a request")
  `PIQ_ASSERT_SAME(a_scan_nonzero, st_r == S_SCAN, scan_r != '0,
                   "scan with zero left")
  `PIQ_ASSERT_NEXT(a_remove_dec, in_fire && in_op == OP_REMOVE && count_r != '0,
                   (count_r + CW'(1)) == $past(count_r), "remove did not decrement")

endmodule

// File: src/piq_cell.sv
module piq_cell #(
  parameter int CW    = 5,
  parameter int INDEX = 0
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  piq_pkg::cell_cmd_t          cmd,
  input  logic [CW-1:0]               pos,
  input  logic [CW-1:0]               count,
  input  logic [piq_pkg::PAIR_W-1:0]  left_data,
  input  logic [piq_pkg::PAIR_W-1:0]  right_data,
  input  logic                        right_tok,
  output logic [piq_pkg::PAIR_W-1:0]  data_o,
  output logic                        tok_o
);
  import piq_pkg::*;

  localparam logic [CW-1:0] IDX = CW'(INDEX);

  logic [PAIR_W-1:0] data_r;
  logic [PAIR_W-1:0] data_nxt;
  logic              tok_r;
  logic              tok_nxt;

  always_comb begin
    data_nxt = data_r;
    tok_nxt  = tok_r;
    case (cmd.op)
      C_INSERT: begin
        if (IDX > pos) begin
          data_nxt = left_data;
        end else if (IDX == pos) begin
          data_nxt = cmd.key;
        end
      end
      C_REMOVE: data_nxt = right_data;
      C_SLOAD:  tok_nxt  = (data_r == cmd.key) && (IDX < count);
      C_SSHIFT: tok_nxt  = right_tok;
      default:  ;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= 1'b0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  assign data_o = data_r;
  assign tok_o  = tok_r;

endmodule

// File: src/piq_chain.sv
module piq_chain #(
  parameter int CAPACITY = piq_pkg::CAPACITY_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  piq_pkg::cell_cmd_t                    cmd,
  input  logic [$clog2(CAPACITY+1)-1:0]         pos,
  input  logic [$clog2(CAPACITY+1)-1:0]         count,
  output logic [piq_pkg::PAIR_W-1:0]            head_data,
  output logic                                  head_tok
);
  import piq_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);

  logic [PAIR_W-1:0] data_w [CAPACITY];
  logic              tok_w  [CAPACITY];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [PAIR_W-1:0] left_d;
    logic [PAIR_W-1:0] right_d;
    logic              right_t;

    if (i == 0) begin : g_head
      assign left_d = cmd.key;
    end else begin : g_mid
      assign left_d = data_w[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_d = '0;
      assign right_t = 1'b0;
    end else begin : g_inner
      assign right_d = data_w[i+1];
      assign right_t = tok_w[i+1];
    end

    piq_cell #(
      .CW    (CW),
      .INDEX (i)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cmd        (cmd),
      .pos        (pos),
      .count      (count),
      .left_data  (left_d),
      .right_data (right_d),
      .right_tok  (right_t),
      .data_o     (data_w[i]),
      .tok_o      (tok_w[i])
    );
  end

  assign head_data = data_w[0];
  assign head_tok  = tok_w[0];

endmodule

// File: verif/tb.sv
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import piq_pkg::*;

  localparam int QUEUE_DEPTH  = CAPACITY_DEF;
  localparam int RANDOM_ITEMS = 1000;
  localparam int STALL_LIMIT  = 4000;  // cycles with no request or result moving
  localparam int TAIL_CYCLES  = 2 * QUEUE_DEPTH + 8;
  localparam int MAX_REPORTS  = 10;

  // One row of the directed script. Rows with typed set carry their outcome;
  // the rest are checked against the queue predictor.
  typedef struct packed {
    oper_e         op;
    logic [4:0]    pos;
    logic [15:0]   x;
    logic [15:0]   y;
    logic [4:0]    reps;
    logic          typed;
    result_t       want;
  } script_row_t;

  logic clk;
  logic rst_n = 1'b0;

  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;   // [4:0] position, [20:5] x, [36:21] y, zero
  logic [OPER_W-1:0]     in_tuser   = '0;   // [1:0] operation
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;         // status, removed_x, removed_y, found, occupancy

  // Predictor state: the pairs held, head at index 0, packed as {y, x}.
  logic [PAIR_W-1:0] held_pairs [QUEUE_DEPTH];
  int                held_count = 0;

  result_t awaited_results [$];
  int      fault_count  = 0;
  int      idle_cycles  = 0;
  bit      source_steady = 1'b0;
  bit      sink_steady   = 1'b0;
  int      sink_hold     = 0;

  positional_insert_queue #(.CAPACITY(QUEUE_DEPTH)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic result_t outcome(stat_e status, logic [4:0] occupancy);
    result_t r;
    r           = '0;
    r.status    = status;
    r.occupancy = occupancy;
    return r;
  endfunction

  // Apply one request to the predicted queue and return the result it causes.
  function automatic result_t predict_queue_op(oper_e op, logic [4:0] pos,
                                               logic [15:0] x, logic [15:0] y);
    result_t           r;
    logic [PAIR_W-1:0] pair;
    int                slot;
    int                k;
    r        = '0;
    r.status = STAT_OK;
    pair     = {y, x};
    case (op)
      OP_APPEND, OP_INSERT: begin
        slot = (op == OP_APPEND) ? held_count : int'(pos);
        // An index past the tail is rejected before the full check.
        if (slot > held_count) begin
          r.status = STAT_RANGE;
        end else if (held_count >= QUEUE_DEPTH) begin
          r.status = STAT_FULL;
        end else begin
          for (k = held_count; k > slot; k--) held_pairs[k] = held_pairs[k-1];
          held_pairs[slot] = pair;
          held_count++;
        end
      end
      OP_REMOVE: begin
        if (held_count == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          r.removed_x = held_pairs[0][COORD_W-1:0];
          r.removed_y = held_pairs[0][PAIR_W-1:COORD_W];
          for (k = 1; k < held_count; k++) held_pairs[k-1] = held_pairs[k];
          held_count--;
        end
      end
      default: begin
        // A match needs both coordinates equal.
        for (k = 0; k < held_count; k++) begin
          if (held_pairs[k] == pair) r.found = 1'b1;
        end
      end
    endcase
    r.occupancy = held_count[4:0];
    return r;
  endfunction

  function automatic void log_fault(string msg);
    fault_count++;
    if (fault_count <= MAX_REPORTS) $display("%s", msg);
  endfunction

  // Mostly back to back, some short gaps, a few long ones.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Favor extremes and a few small values so that duplicates and matches occur.
  function automatic logic [15:0] pick_coord();
    case ($urandom_range(0, 7))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return 16'hffff;
      3, 4:    return 16'($urandom_range(0, 3));
      default: return 16'($urandom);
    endcase
  endfunction

  // Present one request, hold it until taken, then log its expected result.
  task automatic issue_request(oper_e op, logic [4:0] pos, logic [15:0] x,
                               logic [15:0] y, logic typed, result_t want);
    int      gap;
    result_t forecast;
    gap = source_steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {3'b000, y, x, pos};
    in_tuser  <= op;
    do @(posedge clk); while (!in_tready);
    forecast = predict_queue_op(op, pos, x, y);
    awaited_results.push_back(typed ? want : forecast);
  endtask

  // Drop valid and wait until every outstanding result has come back.
  task automatic hold_until_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (awaited_results.size() != 0);
  endtask

  // Result side: ready with random stalls, plus long stretches without any.
  always @(posedge clk) begin
    if (sink_hold > 0) begin
      sink_hold  <= sink_hold - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      if (!sink_steady && $urandom_range(0, 3) == 0) sink_hold <= pick_gap();
    end
    if ($urandom_range(0, 499) == 0) sink_steady <= !sink_steady;
  end

  // Check each accepted result against the oldest expectation, field by field.
  always @(posedge clk) begin
    result_t got;
    result_t exp;
    got = out_tdata;
    if (rst_n && out_tvalid && out_tready) begin
      if (awaited_results.size() == 0) begin
        log_fault($sformatf("unexpected result %h with no request pending", out_tdata));
      end else begin
        exp = awaited_results.pop_front();
        if (got.status !== exp.status || got.removed_x !== exp.removed_x ||
            got.removed_y !== exp.removed_y || got.found !== exp.found ||
            got.occupancy !== exp.occupancy) begin
          log_fault($sformatf(
            "mismatch: exp status %0d rx %h ry %h found %0d occ %0d, got status %0d rx %h ry %h found %0d occ %0d",
            exp.status, exp.removed_x, exp.removed_y, exp.found, exp.occupancy,
            got.status, got.removed_x, got.removed_y, got.found, got.occupancy));
        end
      end
    end
  end

  // Watchdog: end the run when nothing moves on either side for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    script_row_t script [18];
    script_row_t row;
    oper_e       op;
    logic [4:0]  pos;
    logic [15:0] x;
    logic [15:0] y;
    int          grow_bias;
    int          pick;

    // Directed script: empty-queue errors, position extremes, coordinate
    // extremes, a partial match, filling to capacity and the full-store errors.
    script = '{
      '{OP_REMOVE, 5'd0,  16'h0000, 16'h0000, 5'd1,  1'b1, outcome(STAT_EMPTY, 5'd0)},
      '{OP_SEARCH, 5'd0,  16'h0000, 16'h0000, 5'd1,  1'b1, outcome(STAT_OK, 5'd0)},
      '{OP_INSERT, 5'd1,  16'h0007, 16'h0007, 5'd1,  1'b1, outcome(STAT_RANGE, 5'd0)},
      '{OP_INSERT, 5'd31, 16'hffff, 16'hffff, 5'd1,  1'b1, outcome(STAT_RANGE, 5'd0)},
      '{OP_INSERT, 5'd0,  16'h8000, 16'h7fff, 5'd1,  1'b1, outcome(STAT_OK, 5'd1)},
      '{OP_APPEND, 5'd0,  16'h7fff, 16'h8000, 5'd1,  1'b1, outcome(STAT_OK, 5'd2)},
      '{OP_INSERT, 5'd0,  16'h0000, 16'h0000, 5'd1,  1'b0, result_t'('0)},
      '{OP_INSERT, 5'd3,  16'hffff, 16'hffff, 5'd1,  1'b0, result_t'('0)},
      '{OP_INSERT, 5'd2,  16'h0001, 16'hffff, 5'd1,  1'b0, result_t'('0)},
      '{OP_SEARCH, 5'd0,  16'h8000, 16'h7fff, 5'd1,  1'b0, result_t'('0)},
      '{OP_SEARCH, 5'd0,  16'h7fff, 16'h7fff, 5'd1,  1'b0, result_t'('0)},
      '{OP_REMOVE, 5'd0,  16'h0000, 16'h0000, 5'd1,  1'b0, result_t'('0)},
      '{OP_APPEND, 5'd21, 16'h5555, 16'haaaa, 5'd12, 1'b0, result_t'('0)},
      '{OP_APPEND, 5'd0,  16'haaaa, 16'h5555, 5'd1,  1'b1, outcome(STAT_FULL, 5'd16)},
      '{OP_INSERT, 5'd16, 16'h1234, 16'h4321, 5'd1,  1'b1, outcome(STAT_FULL, 5'd16)},
      '{OP_INSERT, 5'd17, 16'h1234, 16'h4321, 5'd1,  1'b1, outcome(STAT_RANGE, 5'd16)},
      '{OP_SEARCH, 5'd0,  16'h5555, 16'haaaa, 5'd1,  1'b0, result_t'('0)},
      '{OP_REMOVE, 5'd0,  16'h0000, 16'h0000, 5'd1,  1'b0, result_t'('0)}
    };

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    foreach (script[i]) begin
      row = script[i];
      repeat (row.reps) issue_request(row.op, row.pos, row.x, row.y, row.typed, row.want);
    end

    // Random part: bias toward growth or shrinkage in phases so the queue
    // swings between empty and full, with searches aimed at held pairs.
    grow_bias = 50;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 100 == 0) begin
        case ($urandom_range(0, 3))
          0:       grow_bias = 15;
          1:       grow_bias = 85;
          2:       grow_bias = 50;
          default: grow_bias = $urandom_range(0, 100);
        endcase
      end
      if (n % 64 == 0) source_steady = ($urandom_range(0, 3) == 0);
      // Hold off until the queue has drained at least once, then now and then.
      if (n == RANDOM_ITEMS / 2 || $urandom_range(0, 149) == 0) hold_until_drained();

      x   = pick_coord();
      y   = pick_coord();
      pos = 5'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
        op = oper_e'($urandom_range(0, 3));       // noise: anything the fields allow
      end else if (pick < 25) begin
        op = OP_SEARCH;
        if (held_count > 0 && $urandom_range(0, 1) == 0) begin
          {y, x} = held_pairs[$urandom_range(0, held_count - 1)];
          if ($urandom_range(0, 9) == 0) y[$urandom_range(0, 15)] ^= 1'b1;
        end
      end else if ($urandom_range(0, 99) < grow_bias) begin
        op = ($urandom_range(0, 1) == 0) ? OP_APPEND : OP_INSERT;
        if (op == OP_INSERT && $urandom_range(0, 99) < 85) begin
          pos = 5'($urandom_range(0, held_count));
        end
      end else begin
        op = OP_REMOVE;
      end
      issue_request(op, pos, x, y, 1'b0, result_t'('0));
    end

    // Drain, give the block time to show any stray result, then report.
    in_tvalid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fault_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
